FILE: design/isqrt_pkg.sv
// ----------------------------------------------------------------------------
// isqrt_pkg - shared definitions for the integer square root block
// Widths of the item fields, the mode encoding and the sequencer state type.
// ----------------------------------------------------------------------------
package isqrt_pkg;

   localparam int MODE_W            = 3;
   localparam int OPERAND_W         = 64;
   localparam int ROOT_W            = 64;
   localparam int MAX_WIDTH_DEFAULT = 64;

   // mode[1:0] picks 8 << n bits, mode[2] marks a signed type
   localparam int MODE_SIGNED_BIT = 2;
   localparam int BASE_WIDTH      = 8;
   localparam int WIDTH_W         = 7;   // holds 8..64

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_WRITE
   } state_type;

endpackage

FILE: design/isqrt_req_if.sv
// ----------------------------------------------------------------------------
// isqrt_req_if - request channel of the integer square root block
// Valid/ready handshake carrying the type mode and the operand pattern.
// ----------------------------------------------------------------------------
interface isqrt_req_if;
   logic                               valid;
   logic                               ready;
   logic [isqrt_pkg::MODE_W-1:0]       mode;
   logic [isqrt_pkg::OPERAND_W-1:0]    operand;

   modport source (output valid, output mode, output operand, input ready);
   modport sink   (input valid, input mode, input operand, output ready);
endinterface

FILE: design/isqrt_rsp_if.sv
// ----------------------------------------------------------------------------
// isqrt_rsp_if - response channel of the integer square root block
// Valid/ready handshake carrying the 64-bit root.
// ----------------------------------------------------------------------------
interface isqrt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [isqrt_pkg::ROOT_W-1:0]     root;

   modport source (output valid, output root, input ready);
   modport sink   (input valid, input root, output ready);
endinterface

FILE: design/integer_square_root.sv
// ----------------------------------------------------------------------------
// integer_square_root - floor square root of an 8/16/32/64-bit integer
// Restoring digit recurrence, one root bit per cycle on a shared
// shift/compare/subtract unit.
// ----------------------------------------------------------------------------
// An item carries a 3-bit mode (0 u8, 1 u16, 2 u32, 3 u64, 4 s8 .. 7 s64)
// and a 64-bit operand; only the low bits of the selected width are used
// (width capped at MAX_WIDTH, itself clamped to 8..64, sign then taken from
// the top bit of the capped width). The result is the floor root,
// zero-extended to 64 bits; a negative signed operand comes back as its own
// masked pattern. Sequence: the item is taken in ST_IDLE, the recurrence
// runs ceil(WIDTH_CAP/2) steps, one per cycle, on a single compare/subtract
// unit in ST_CALC, and ST_WRITE loads the output register once it is free,
// after which the unit returns to ST_IDLE for the next item.
// Negative signed operands skip the recurrence and go from ST_IDLE
// straight to ST_WRITE.
// req_chan.ready is low while the unit is busy. The result sits in its own
// output register, so the next item is taken as soon as the unit is free,
// even while the previous result still waits on rsp_chan.ready.
// ----------------------------------------------------------------------------
module integer_square_root #(
   parameter int MAX_WIDTH = isqrt_pkg::MAX_WIDTH_DEFAULT
) (
   input logic           clock,
   input logic           reset,
   isqrt_req_if.sink     req_chan,
   isqrt_rsp_if.source   rsp_chan
);

   // widest operand, held to 8..64
   localparam int WIDTH_CAP = (MAX_WIDTH < 8)  ? 8  :
                              (MAX_WIDTH > 64) ? 64 : MAX_WIDTH;

   // recurrence sizes: PAIRS root bits, radicand padded to an even width
   localparam int PAIRS = (WIDTH_CAP + 1) / 2;
   localparam int RAD_W = 2 * PAIRS;
   localparam int REM_W = PAIRS + 2;
   localparam int CNT_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam logic [isqrt_pkg::WIDTH_W-1:0] WIDTH_LIMIT =
      isqrt_pkg::WIDTH_W'(WIDTH_CAP);

   isqrt_pkg::state_type state_ff, state_in;

   logic [RAD_W-1:0]                 rad_ff, rad_in;
   logic [REM_W-1:0]                 rem_ff, rem_in;
   logic [PAIRS-1:0]                 root_ff, root_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic                             neg_ff, neg_in;
   logic                             out_valid_ff, out_valid_in;
   logic [isqrt_pkg::ROOT_W-1:0]     out_root_ff, out_root_in;

   // decode of the incoming item
   logic [isqrt_pkg::WIDTH_W-1:0]    width_raw;
   logic [isqrt_pkg::WIDTH_W-1:0]    width_sel;
   logic [RAD_W-1:0]                 value_masked;
   logic                             value_sign;
   logic                             value_neg;

   // shared recurrence unit
   logic [REM_W-1:0]                 rem_shift;
   logic [REM_W-1:0]                 trial;
   logic                             take_bit;

   logic                             out_free;

   assign out_free = !out_valid_ff || rsp_chan.ready;

   // width = 8 << mode[1:0], capped at MAX_WIDTH
   always_comb begin
      width_raw = isqrt_pkg::WIDTH_W'(isqrt_pkg::BASE_WIDTH) << req_chan.mode[1:0];
      width_sel = (width_raw > WIDTH_LIMIT) ? WIDTH_LIMIT : width_raw;
   end

   // mask to the width and pick out the sign bit
   always_comb begin
      value_masked = '0;
      value_sign   = 1'b0;
      for (int i = 0; i < RAD_W; i++) begin
         if ((i < WIDTH_CAP) && (isqrt_pkg::WIDTH_W'(i) < width_sel)) begin
            value_masked[i] = req_chan.operand[i];
         end
         if ((i < WIDTH_CAP) && (isqrt_pkg::WIDTH_W'(i + 1) == width_sel)) begin
            value_sign = req_chan.operand[i];
         end
      end
      value_neg = req_chan.mode[isqrt_pkg::MODE_SIGNED_BIT] && value_sign;
   end

   // one recurrence step: bring down two bits, try (root << 2) | 1
   always_comb begin
      rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial     = {root_ff, 2'b01};
      take_bit  = (rem_shift >= trial);
   end

   // sequencer: next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_root_in  = out_root_ff;
      req_chan.ready = 1'b0;

      case (state_ff)
         isqrt_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               rad_in  = value_masked;
               rem_in  = '0;
               root_in = '0;
               cnt_in  = CNT_W'(PAIRS - 1);
               neg_in  = value_neg;
               state_in = value_neg ? isqrt_pkg::ST_WRITE : isqrt_pkg::ST_CALC;
            end
         end
         isqrt_pkg::ST_CALC: begin
            rad_in  = rad_ff << 2;
            rem_in  = take_bit ? (rem_shift - trial) : rem_shift;
            root_in = {root_ff[PAIRS-2:0], take_bit};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = isqrt_pkg::ST_WRITE;
            end
         end
         isqrt_pkg::ST_WRITE: begin
            // hold here until the output register is free
            if (out_free) begin
               out_valid_in = 1'b1;
               out_root_in  = neg_ff ? isqrt_pkg::ROOT_W'(rad_ff)
                                     : isqrt_pkg::ROOT_W'(root_ff);
               state_in     = isqrt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = isqrt_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= isqrt_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      out_root_ff <= out_root_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.root  = out_root_ff;

endmodule

FILE: design/isqrt_checker.sv
// ----------------------------------------------------------------------------
// isqrt_checker - port-level checks for the integer square root block
// Watches both handshakes; bound to the top level below.
// ----------------------------------------------------------------------------
module isqrt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [isqrt_pkg::ROOT_W-1:0]    rsp_root
);

   // a result waiting on the sink stays up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // and keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_root))
      else $error("rsp root changed while stalled");

   // unit goes busy straight after taking an item
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req ready still high after accept");

   // a new result only appears as the unit comes free
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result raised while unit still busy");

endmodule

bind integer_square_root isqrt_checker u_isqrt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_root  (rsp_chan.root)
);
